@@ rtl/qslp_pkg.sv @@
// Shared types, constants and the arctangent table for the quaternion slerp block.
// No dependencies; every rtl file refers to it by scoped names.
package qslp_pkg;

    localparam int ANGLE_STEPS = 16;
    localparam int TABLE_LEN   = 24;
    localparam int SQRT_STEPS  = 31;
    localparam int DIV_STEPS   = 47;
    localparam int QDEPTH      = 4;
    localparam int QAW         = 2;

    localparam logic [11:0]        EPS_RESET = 12'd7;
    localparam logic signed [33:0] GAIN_INV  = 34'sd652032874;

    typedef enum logic [1:0] {
        KIND_SLERP,
        KIND_FROM,
        KIND_TO
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              neg;
        logic [27:0]       dot;
        logic [16:0]       ratio;
        logic [3:0][15:0]  fq;
        logic [3:0][15:0]  tq;
    } t_word;

    function automatic logic [31:0] atan_at(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/quaternion_slerp.sv @@
// Top level of the quaternion slerp block: front end, word queue, arithmetic pipeline.
// Depends on qslp_pkg, qslp_front, qslp_fifo and qslp_back.
//
//   channel   direction  handshake                     payload
//   in        input      i_in_valid / o_in_ready       i_from_*, i_to_*, i_ratio
//   out       output     o_out_valid / i_out_ready     o_out_x/y/z/w
//   cfg       input      i_cfg_we                      i_cfg_wdata (epsilon)
//
// One word per cycle sustained while the output is not stalled; the arithmetic
// path runs through the 31-step square root, two 16-step CORDIC chains and the
// 47-step dividers.
// Reset is synchronous: clears valid bits, queue pointers, epsilon to 7.
// An output stall freezes the arithmetic pipeline; the front end keeps
// taking words until the four-entry queue fills.
module quaternion_slerp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [11:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_from_x,
    input  logic signed [15:0]  i_from_y,
    input  logic signed [15:0]  i_from_z,
    input  logic signed [15:0]  i_from_w,
    input  logic signed [15:0]  i_to_x,
    input  logic signed [15:0]  i_to_y,
    input  logic signed [15:0]  i_to_z,
    input  logic signed [15:0]  i_to_w,
    input  logic [16:0]         i_ratio,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_out_x,
    output logic signed [15:0]  o_out_y,
    output logic signed [15:0]  o_out_z,
    output logic signed [15:0]  o_out_w
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    qslp_pkg::t_word  push_word;
    qslp_pkg::t_word  head_word;

    qslp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_from_x    (i_from_x),
        .i_from_y    (i_from_y),
        .i_from_z    (i_from_z),
        .i_from_w    (i_from_w),
        .i_to_x      (i_to_x),
        .i_to_y      (i_to_y),
        .i_to_z      (i_to_z),
        .i_to_w      (i_to_w),
        .i_ratio     (i_ratio),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_word      (push_word)
    );

    qslp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_word  (head_word)
    );

    qslp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_word    (head_word),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_w     (o_out_w)
    );

endmodule

@@ rtl/qslp_front.sv @@
// Front end: epsilon register, input capture, ratio classification and dot product.
// Depends on qslp_pkg; feeds qslp_fifo.
module qslp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [11:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_from_x,
    input  logic signed [15:0]  i_from_y,
    input  logic signed [15:0]  i_from_z,
    input  logic signed [15:0]  i_from_w,
    input  logic signed [15:0]  i_to_x,
    input  logic signed [15:0]  i_to_y,
    input  logic signed [15:0]  i_to_z,
    input  logic signed [15:0]  i_to_w,
    input  logic [16:0]         i_ratio,
    input  logic                i_q_full,
    output logic                o_push,
    output qslp_pkg::t_word     o_word
);

    logic [11:0]          r_eps;
    logic                 r_f1_valid;
    logic [3:0][15:0]     r_f1_fq;
    logic [3:0][15:0]     r_f1_tq;
    logic [16:0]          r_f1_ratio;
    qslp_pkg::t_kind      r_f1_kind;
    logic                 r_f2_valid;
    logic [3:0][15:0]     r_f2_fq;
    logic [3:0][15:0]     r_f2_tq;
    logic [16:0]          r_f2_ratio;
    qslp_pkg::t_kind      r_f2_kind;
    logic signed [31:0]   r_f2_prod [4];

    logic                 f_en;
    logic [16:0]          hi_lim;
    qslp_pkg::t_kind      n_kind;
    logic signed [33:0]   dsum;
    logic [33:0]          absd;
    logic                 dneg;

    assign f_en       = !r_f2_valid || !i_q_full;
    assign o_in_ready = f_en;
    assign hi_lim     = 17'h10000 - {5'b0, r_eps};

    always_comb begin
        if (i_ratio < {5'b0, r_eps}) begin
            n_kind = qslp_pkg::KIND_FROM;
        end else if (i_ratio > hi_lim) begin
            n_kind = qslp_pkg::KIND_TO;
        end else begin
            n_kind = qslp_pkg::KIND_SLERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps      <= qslp_pkg::EPS_RESET;
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            if (f_en) begin
                r_f1_valid <= i_in_valid;
                r_f2_valid <= r_f1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_f1_fq    <= {i_from_w, i_from_z, i_from_y, i_from_x};
            r_f1_tq    <= {i_to_w, i_to_z, i_to_y, i_to_x};
            r_f1_ratio <= i_ratio;
            r_f1_kind  <= n_kind;
            r_f2_fq    <= r_f1_fq;
            r_f2_tq    <= r_f1_tq;
            r_f2_ratio <= r_f1_ratio;
            r_f2_kind  <= r_f1_kind;
            for (int i = 0; i < 4; i++) begin
                r_f2_prod[i] <= $signed(r_f1_fq[i]) * $signed(r_f1_tq[i]);
            end
        end
    end

    assign dsum = 34'(r_f2_prod[0]) + 34'(r_f2_prod[1]) + 34'(r_f2_prod[2])
                + 34'(r_f2_prod[3]);
    assign dneg = dsum < 0;
    assign absd = dneg ? 34'(-dsum) : 34'(dsum);

    always_comb begin
        o_word.kind  = r_f2_kind;
        if (r_f2_kind == qslp_pkg::KIND_SLERP && absd[33:28] != 6'd0) begin
            o_word.kind = qslp_pkg::KIND_TO;
        end
        o_word.neg   = dneg;
        o_word.dot   = absd[27:0];
        o_word.ratio = r_f2_ratio;
        o_word.fq    = r_f2_fq;
        o_word.tq    = r_f2_tq;
    end

    assign o_push = r_f2_valid && !i_q_full;

endmodule

@@ rtl/qslp_fifo.sv @@
// Short word queue between the front end and the arithmetic pipeline.
// Depends on qslp_pkg for the word type and depth.
module qslp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qslp_pkg::t_word  i_word,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output qslp_pkg::t_word  o_word
);

    qslp_pkg::t_word            r_mem [qslp_pkg::QDEPTH];
    logic [qslp_pkg::QAW-1:0]   r_wp;
    logic [qslp_pkg::QAW-1:0]   r_rp;
    logic [qslp_pkg::QAW:0]     r_cnt;

    assign o_full  = r_cnt == (qslp_pkg::QAW + 1)'(qslp_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule

@@ rtl/qslp_back.sv @@
// Arithmetic pipeline: square root, CORDIC angle, CORDIC sines, dividers, blend, output reg.
// Depends on qslp_pkg; takes words from qslp_fifo.
module qslp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  qslp_pkg::t_word     i_q_word,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_out_x,
    output logic signed [15:0]  o_out_y,
    output logic signed [15:0]  o_out_z,
    output logic signed [15:0]  o_out_w
);

    localparam int NS   = qslp_pkg::SQRT_STEPS;
    localparam int NA   = qslp_pkg::ANGLE_STEPS;
    localparam int ND   = qslp_pkg::DIV_STEPS;
    localparam int P_S  = 2 + NS;
    localparam int P_W  = P_S + NA;
    localparam int P_A  = P_W + 1;
    localparam int P_SN = P_A + NA;
    localparam int P_D  = P_SN + 1;
    localparam int P_Q  = P_D + ND;
    localparam int P_SC = P_Q + 1;
    localparam int P_PR = P_SC + 1;

    logic                 b_en;
    logic                 r_o_valid;
    logic signed [15:0]   r_o [4];

    qslp_pkg::t_word      r_wd [0:P_PR];
    logic [P_PR:0]        r_vd;

    assign b_en        = !r_o_valid || i_out_ready;
    assign o_pop       = b_en && !i_q_empty;
    assign o_out_valid = r_o_valid;
    assign o_out_x     = r_o[0];
    assign o_out_y     = r_o[1];
    assign o_out_z     = r_o[2];
    assign o_out_w     = r_o[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd      <= '0;
            r_o_valid <= 1'b0;
        end else if (b_en) begin
            r_vd      <= {r_vd[P_PR-1:0], !i_q_empty};
            r_o_valid <= r_vd[P_PR];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_wd[0] <= i_q_word;
            for (int i = 1; i <= P_PR; i++) begin
                r_wd[i] <= r_wd[i-1];
            end
        end
    end

    // c squared, then the radicand
    logic [29:0] c0;
    logic [59:0] r_sq;
    logic [61:0] r_sv [0:NS];
    logic [61:0] r_sr [0:NS];

    assign c0 = {r_wd[0].dot, 2'b00};

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_sq    <= c0 * c0;
            r_sv[0] <= (62'(1) << 60) - {2'b00, r_sq};
            r_sr[0] <= '0;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        logic [61:0] bitv;
        logic [61:0] trial;
        assign bitv  = 62'(1) << (2 * (NS - 1 - j));
        assign trial = r_sr[j] + bitv;
        always_ff @(posedge i_clk) begin
            if (b_en) begin
                if (r_sv[j] >= trial) begin
                    r_sv[j+1] <= r_sv[j] - trial;
                    r_sr[j+1] <= (r_sr[j] >> 1) + bitv;
                end else begin
                    r_sv[j+1] <= r_sv[j];
                    r_sr[j+1] <= r_sr[j] >> 1;
                end
            end
        end
    end

    logic [30:0] s_fin;
    logic [29:0] c_s;
    assign s_fin = r_sr[NS][30:0];
    assign c_s   = {r_wd[P_S].dot, 2'b00};

    // sine of the full angle travels beside the word up to the dividers
    logic [30:0] r_sl [P_S+1:P_Q];
    for (genvar i = P_S + 1; i <= P_Q; i++) begin : g_sline
        always_ff @(posedge i_clk) begin
            if (b_en) begin
                if (i == P_S + 1) begin
                    r_sl[i] <= s_fin;
                end else begin
                    r_sl[i] <= r_sl[i-1];
                end
            end
        end
    end

    // vectoring CORDIC: angle of (c, s)
    logic signed [33:0] vx_in [0:NA-1];
    logic signed [33:0] vy_in [0:NA-1];
    logic signed [32:0] vz_in [0:NA-1];
    logic signed [33:0] r_vx [1:NA];
    logic signed [33:0] r_vy [1:NA];
    logic signed [32:0] r_vz [1:NA];

    for (genvar i = 0; i < NA; i++) begin : g_vec
        logic signed [32:0] at;
        assign at = $signed({1'b0, qslp_pkg::atan_at(i)});
        if (i == 0) begin : g_first
            assign vx_in[i] = $signed({4'b0, c_s});
            assign vy_in[i] = $signed({3'b0, s_fin});
            assign vz_in[i] = '0;
        end else begin : g_next
            assign vx_in[i] = r_vx[i];
            assign vy_in[i] = r_vy[i];
            assign vz_in[i] = r_vz[i];
        end
        always_ff @(posedge i_clk) begin
            if (b_en) begin
                if (vy_in[i] >= 0) begin
                    r_vx[i+1] <= vx_in[i] + (vy_in[i] >>> i);
                    r_vy[i+1] <= vy_in[i] - (vx_in[i] >>> i);
                    r_vz[i+1] <= vz_in[i] + at;
                end else begin
                    r_vx[i+1] <= vx_in[i] - (vy_in[i] >>> i);
                    r_vy[i+1] <= vy_in[i] + (vx_in[i] >>> i);
                    r_vz[i+1] <= vz_in[i] - at;
                end
            end
        end
    end

    // partial angles
    logic [30:0] w31;
    logic [16:0] rc0;
    logic [47:0] m0;
    logic [47:0] m1;
    logic [30:0] r_a [2];

    assign w31 = r_vz[NA][32] ? 31'd0 : r_vz[NA][30:0];
    assign rc0 = 17'h10000 - r_wd[P_W].ratio;
    assign m0  = w31 * rc0;
    assign m1  = w31 * r_wd[P_W].ratio;

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_a[0] <= m0[46:16];
            r_a[1] <= m1[46:16];
        end
    end

    // rotation CORDIC sines, two lanes
    logic signed [33:0] nx_in [2][0:NA-1];
    logic signed [33:0] ny_in [2][0:NA-1];
    logic signed [32:0] nz_in [2][0:NA-1];
    logic signed [33:0] r_nx [2][1:NA];
    logic signed [33:0] r_ny [2][1:NA];
    logic signed [32:0] r_nz [2][1:NA];

    // dividers, two lanes
    logic [30:0] r_dr [2][0:ND];
    logic [46:0] r_dn [2][0:ND];
    logic [46:0] r_dq [2][0:ND];
    logic        r_dg [2][0:ND];
    logic signed [47:0] r_sc [2];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar i = 0; i < NA; i++) begin : g_rot
            logic signed [32:0] at;
            assign at = $signed({1'b0, qslp_pkg::atan_at(i)});
            if (i == 0) begin : g_first
                assign nx_in[l][i] = qslp_pkg::GAIN_INV;
                assign ny_in[l][i] = '0;
                assign nz_in[l][i] = $signed({2'b00, r_a[l]});
            end else begin : g_next
                assign nx_in[l][i] = r_nx[l][i];
                assign ny_in[l][i] = r_ny[l][i];
                assign nz_in[l][i] = r_nz[l][i];
            end
            always_ff @(posedge i_clk) begin
                if (b_en) begin
                    if (nz_in[l][i] >= 0) begin
                        r_nx[l][i+1] <= nx_in[l][i] - (ny_in[l][i] >>> i);
                        r_ny[l][i+1] <= ny_in[l][i] + (nx_in[l][i] >>> i);
                        r_nz[l][i+1] <= nz_in[l][i] - at;
                    end else begin
                        r_nx[l][i+1] <= nx_in[l][i] + (ny_in[l][i] >>> i);
                        r_ny[l][i+1] <= ny_in[l][i] - (nx_in[l][i] >>> i);
                        r_nz[l][i+1] <= nz_in[l][i] + at;
                    end
                end
            end
        end

        logic               sneg;
        logic [33:0]        smag;
        assign sneg = r_ny[l][NA] < 0;
        assign smag = sneg ? 34'(-r_ny[l][NA]) : 34'(r_ny[l][NA]);

        // numerator is |sin| << 30; its top 16 bits are below s
        always_ff @(posedge i_clk) begin
            if (b_en) begin
                r_dr[l][0] <= {15'b0, smag[32:17]};
                r_dn[l][0] <= {smag[16:0], 30'b0};
                r_dq[l][0] <= '0;
                r_dg[l][0] <= sneg;
            end
        end

        for (genvar k = 0; k < ND; k++) begin : g_div
            logic [31:0] rem2;
            logic [31:0] dsr;
            logic        ge;
            logic [31:0] dif;
            assign rem2 = {r_dr[l][k], r_dn[l][k][46]};
            assign dsr  = {1'b0, r_sl[P_D+k]};
            assign ge   = rem2 >= dsr;
            assign dif  = rem2 - dsr;
            always_ff @(posedge i_clk) begin
                if (b_en) begin
                    r_dr[l][k+1] <= ge ? dif[30:0] : rem2[30:0];
                    r_dn[l][k+1] <= {r_dn[l][k][45:0], 1'b0};
                    r_dq[l][k+1] <= {r_dq[l][k][45:0], ge};
                    r_dg[l][k+1] <= r_dg[l][k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (b_en) begin
                r_sc[l] <= r_dg[l][ND] ? -$signed({1'b0, r_dq[l][ND]})
                                       :  $signed({1'b0, r_dq[l][ND]});
            end
        end
    end

    // blend products
    logic signed [63:0] r_p0 [4];
    logic signed [64:0] r_p1 [4];
    logic signed [16:0] tf [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            tf[i] = r_wd[P_SC].neg ? -17'($signed(r_wd[P_SC].tq[i]))
                                   :  17'($signed(r_wd[P_SC].tq[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            for (int i = 0; i < 4; i++) begin
                r_p0[i] <= $signed(r_wd[P_SC].fq[i]) * r_sc[0];
                r_p1[i] <= tf[i] * r_sc[1];
            end
        end
    end

    logic signed [65:0] acc [4];
    logic signed [35:0] rnd [4];
    logic signed [15:0] sat [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            acc[i] = 66'(r_p0[i]) + 66'(r_p1[i]) + 66'sd536870912;
            rnd[i] = 36'(acc[i] >>> 30);
            if (rnd[i] > 36'sd32767) begin
                sat[i] = 16'sh7FFF;
            end else if (rnd[i] < -36'sd32768) begin
                sat[i] = -16'sh8000;
            end else begin
                sat[i] = rnd[i][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            for (int i = 0; i < 4; i++) begin
                unique case (r_wd[P_PR].kind)
                    qslp_pkg::KIND_FROM: r_o[i] <= $signed(r_wd[P_PR].fq[i]);
                    qslp_pkg::KIND_TO:   r_o[i] <= $signed(r_wd[P_PR].tq[i]);
                    default:             r_o[i] <= sat[i];
                endcase
            end
        end
    end

endmodule
